// ----- hdl/wcg_pkg.sv -----
// wcg_pkg: widths, constants, register codes and stage types for the window
// coefficient generator. No dependencies; every other file imports it.
package wcg_pkg;

    localparam int FRAME_LEN_W = 13;
    localparam int KIND_W      = 2;
    localparam int INDEX_W     = 12;
    localparam int COEF_W      = 17;
    localparam int MAX_FRAME   = 4096;
    localparam int DIV_W       = $clog2(MAX_FRAME);

    localparam int PHASE_W     = 24;
    localparam int DIV_STAGES  = INDEX_W + PHASE_W;

    localparam int CORDIC_ITERS = 24;
    localparam int CORDIC_W     = 34;
    localparam int LANES        = 2;

    localparam int TWO_PI_W = 33;
    localparam logic [TWO_PI_W-1:0] TWO_PI_Q30 = 33'd6746518853;
    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN_INV = 34'sd652032874;

    localparam logic signed [CORDIC_W-1:0] ATAN_Q30 [CORDIC_ITERS] = '{
        34'sd843314856, 34'sd497837829, 34'sd263043836, 34'sd133525158,
        34'sd67021686,  34'sd33543515,  34'sd16775850,  34'sd8388437,
        34'sd4194282,   34'sd2097149,   34'sd1048575,   34'sd524287,
        34'sd262143,    34'sd131071,    34'sd65535,     34'sd32767,
        34'sd16383,     34'sd8191,      34'sd4095,      34'sd2047,
        34'sd1023,      34'sd511,       34'sd255,       34'sd127
    };

    // window constants in q30
    localparam int Q_FRAC = 30;
    localparam logic [Q_FRAC-1:0] C_HALF = 30'd536870912;
    localparam logic [Q_FRAC-1:0] C_054  = 30'd579820585;
    localparam logic [Q_FRAC-1:0] C_046  = 30'd493921239;
    localparam logic [Q_FRAC-1:0] C_042  = 30'd450971566;
    localparam logic [Q_FRAC-1:0] C_008  = 30'd85899346;

    localparam int COS_W       = 32;
    localparam int PROD_W      = Q_FRAC + 1 + COS_W;
    localparam int ACC_W       = 64;
    localparam int ROUND_SHIFT = 44;
    localparam int RND_W       = ACC_W - ROUND_SHIFT;
    localparam logic [COEF_W-1:0] COEF_ONE = 17'd65536;

    // configuration port
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;
    localparam int REG_SEL_BIT = 2;
    localparam logic REG_FRAME_LENGTH = 1'b0;
    localparam logic REG_WINDOW_KIND  = 1'b1;
    localparam logic [FRAME_LEN_W-1:0] FRAME_LEN_RESET = 13'd1024;

    typedef enum logic [KIND_W-1:0] {
        KIND_HANN     = 2'd0,
        KIND_HAMMING  = 2'd1,
        KIND_BLACKMAN = 2'd2,
        KIND_ZERO     = 2'd3
    } window_kind_t;

    typedef struct packed {
        logic [INDEX_W-1:0] num;
        logic [DIV_W-1:0]   rem;
        logic [PHASE_W-1:0] quot;
    } div_data_t;

    typedef struct packed {
        logic                       neg;
        logic signed [CORDIC_W-1:0] x;
        logic signed [CORDIC_W-1:0] y;
        logic signed [CORDIC_W-1:0] z;
    } cordic_lane_t;

    typedef cordic_lane_t [LANES-1:0] cordic_pair_t;

endpackage

// ----- hdl/wcg_if.sv -----
// wcg_if: valid/ready stream interfaces for the sample index and coefficient
// channels. Depends on wcg_pkg.
interface wcg_index_if;
    import wcg_pkg::*;

    logic               valid;
    logic               ready;
    logic [INDEX_W-1:0] sample_index;

    modport source (output valid, output sample_index, input ready);
    modport sink   (input valid, input sample_index, output ready);
endinterface

interface wcg_coef_if;
    import wcg_pkg::*;

    logic              valid;
    logic              ready;
    logic [COEF_W-1:0] coefficient;

    modport source (output valid, output coefficient, input ready);
    modport sink   (input valid, input coefficient, output ready);
endinterface

// ----- hdl/wcg_div_cell.sv -----
// wcg_div_cell: one restoring division step, one quotient bit per cell.
// Depends on wcg_pkg.
module wcg_div_cell (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic [wcg_pkg::DIV_W-1:0] divisor,
    input  logic                      in_valid,
    input  wcg_pkg::div_data_t        in_data,
    output logic                      out_valid,
    output wcg_pkg::div_data_t        out_data
);
    import wcg_pkg::*;

    logic [DIV_W:0] trial;
    logic           fits;
    logic           valid_reg;
    div_data_t      data_reg;
    div_data_t      data_next;

    always_comb
    begin
        trial = {in_data.rem, in_data.num[INDEX_W-1]};
        fits  = (trial >= {1'b0, divisor});
        data_next.num  = {in_data.num[INDEX_W-2:0], 1'b0};
        data_next.rem  = fits ? DIV_W'(trial - {1'b0, divisor}) : DIV_W'(trial);
        data_next.quot = {in_data.quot[PHASE_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ----- hdl/wcg_cos_prep.sv -----
// wcg_cos_prep: folds the phase into the first quarter turn for both cosine
// lanes and scales it to radians. Depends on wcg_pkg.
module wcg_cos_prep (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [wcg_pkg::PHASE_W-1:0] phase,
    output logic                        out_valid,
    output wcg_pkg::cordic_pair_t       out_lanes
);
    import wcg_pkg::*;

    localparam logic [PHASE_W-1:0] HALF_TURN    = {1'b1, {(PHASE_W-1){1'b0}}};
    localparam logic [PHASE_W-1:0] QUARTER_TURN = {2'b01, {(PHASE_W-2){1'b0}}};
    localparam int PROD_BITS = PHASE_W - 1 + TWO_PI_W;

    logic v1_reg;
    logic v2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    assign out_valid = v2_reg;

    for (genvar l = 0; l < LANES; l++)
    begin : g_lane
        logic [PHASE_W-1:0]   ph;
        logic [PHASE_W-1:0]   f1;
        logic [PHASE_W-1:0]   f2;
        logic                 neg_next;
        logic [PHASE_W-2:0]   fold_reg;
        logic                 neg1_reg;
        logic [PROD_BITS-1:0] zprod;
        logic signed [CORDIC_W-1:0] z_reg;
        logic                 neg2_reg;

        always_comb
        begin
            ph = (l == 0) ? phase : {phase[PHASE_W-2:0], 1'b0};
            f1 = (ph > HALF_TURN) ? (PHASE_W'(0) - ph) : ph;
            if (f1 > QUARTER_TURN)
            begin
                f2       = HALF_TURN - f1;
                neg_next = 1'b1;
            end
            else
            begin
                f2       = f1;
                neg_next = 1'b0;
            end
            zprod = fold_reg * TWO_PI_Q30;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                fold_reg <= f2[PHASE_W-2:0];
                neg1_reg <= neg_next;
                z_reg    <= $signed(CORDIC_W'(zprod[PROD_BITS-1:PHASE_W]));
                neg2_reg <= neg1_reg;
            end
        end

        assign out_lanes[l].neg = neg2_reg;
        assign out_lanes[l].x   = CORDIC_GAIN_INV;
        assign out_lanes[l].y   = '0;
        assign out_lanes[l].z   = z_reg;
    end

endmodule

// ----- hdl/wcg_cordic_cell.sv -----
// wcg_cordic_cell: one rotation-mode cordic iteration for both cosine lanes.
// Depends on wcg_pkg.
module wcg_cordic_cell #(
    parameter int ITER = 0
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  wcg_pkg::cordic_pair_t in_lanes,
    output logic                  out_valid,
    output wcg_pkg::cordic_pair_t out_lanes
);
    import wcg_pkg::*;

    logic         valid_reg;
    cordic_pair_t lanes_reg;
    cordic_pair_t lanes_next;

    logic signed [CORDIC_W-1:0] x;
    logic signed [CORDIC_W-1:0] y;
    logic signed [CORDIC_W-1:0] z;

    always_comb
    begin
        x = '0;
        y = '0;
        z = '0;
        for (int l = 0; l < LANES; l++)
        begin
            x = in_lanes[l].x;
            y = in_lanes[l].y;
            z = in_lanes[l].z;
            lanes_next[l].neg = in_lanes[l].neg;
            if (!z[CORDIC_W-1])
            begin
                lanes_next[l].x = x - (y >>> ITER);
                lanes_next[l].y = y + (x >>> ITER);
                lanes_next[l].z = z - ATAN_Q30[ITER];
            end
            else
            begin
                lanes_next[l].x = x + (y >>> ITER);
                lanes_next[l].y = y - (x >>> ITER);
                lanes_next[l].z = z + ATAN_Q30[ITER];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lanes_reg <= lanes_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_lanes = lanes_reg;

endmodule

// ----- hdl/wcg_mix.sv -----
// wcg_mix: weights the two cosines by the window constants, sums, rounds
// to q1.16 and saturates. Depends on wcg_pkg.
module wcg_mix (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  wcg_pkg::window_kind_t      kind,
    input  logic                       in_valid,
    input  wcg_pkg::cordic_pair_t      in_lanes,
    output logic                       out_valid,
    output logic [wcg_pkg::COEF_W-1:0] coefficient
);
    import wcg_pkg::*;

    localparam logic signed [ACC_W-1:0] BASE_HANN     = $signed(ACC_W'(C_HALF) << Q_FRAC);
    localparam logic signed [ACC_W-1:0] BASE_HAMMING  = $signed(ACC_W'(C_054) << Q_FRAC);
    localparam logic signed [ACC_W-1:0] BASE_BLACKMAN = $signed(ACC_W'(C_042) << Q_FRAC);
    localparam logic [ACC_W-1:0] ROUND_BIAS = ACC_W'(1) << (ROUND_SHIFT - 1);

    logic v0_reg;
    logic v1_reg;
    logic v2_reg;
    logic v3_reg;

    logic signed [COS_W-1:0]  c0_reg;
    logic signed [COS_W-1:0]  c1_reg;
    logic [Q_FRAC-1:0]        a_coef;
    logic [Q_FRAC-1:0]        b_coef;
    logic signed [ACC_W-1:0]  base_val;
    logic signed [Q_FRAC:0]   a_s;
    logic signed [Q_FRAC:0]   b_s;
    logic signed [PROD_W-1:0] prod0_next;
    logic signed [PROD_W-1:0] prod1_next;
    logic signed [PROD_W-1:0] prod0_reg;
    logic signed [PROD_W-1:0] prod1_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [ACC_W-1:0]  acc_reg;
    logic [ACC_W-1:0]         rnd;
    logic [RND_W-1:0]         rounded;
    logic [COEF_W-1:0]        coef_next;
    logic [COEF_W-1:0]        coef_reg;

    always_comb
    begin
        case (kind)
            KIND_HANN:
            begin
                a_coef   = C_HALF;
                b_coef   = '0;
                base_val = BASE_HANN;
            end
            KIND_HAMMING:
            begin
                a_coef   = C_046;
                b_coef   = '0;
                base_val = BASE_HAMMING;
            end
            KIND_BLACKMAN:
            begin
                a_coef   = C_HALF;
                b_coef   = C_008;
                base_val = BASE_BLACKMAN;
            end
            default:
            begin
                a_coef   = '0;
                b_coef   = '0;
                base_val = '0;
            end
        endcase
        a_s        = $signed({1'b0, a_coef});
        b_s        = $signed({1'b0, b_coef});
        prod0_next = a_s * c0_reg;
        prod1_next = b_s * c1_reg;
        acc_next   = base_val - prod0_reg + prod1_reg;

        rnd     = $unsigned(acc_reg) + ROUND_BIAS;
        rounded = rnd[ACC_W-1:ROUND_SHIFT];
        if (acc_reg <= 0)
        begin
            coef_next = '0;
        end
        else if (rounded > RND_W'(COEF_ONE))
        begin
            coef_next = COEF_ONE;
        end
        else
        begin
            coef_next = rounded[COEF_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= in_valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c0_reg <= COS_W'(in_lanes[0].neg ? -in_lanes[0].x : in_lanes[0].x);
            c1_reg <= COS_W'(in_lanes[1].neg ? -in_lanes[1].x : in_lanes[1].x);
            prod0_reg <= prod0_next;
            prod1_reg <= prod1_next;
            acc_reg   <= acc_next;
            coef_reg  <= coef_next;
        end
    end

    assign out_valid   = v3_reg;
    assign coefficient = coef_reg;

endmodule

// ----- hdl/window_coefficient_generator.sv -----
// window_coefficient_generator: top level with the configuration registers,
// the divider, cordic and mixing chains, and the output skid stage.
// Depends on wcg_pkg, wcg_if, wcg_div_cell, wcg_cos_prep, wcg_cordic_cell, wcg_mix.
//
//   channel      direction  payload              transaction
//   idx_stream   in         sample_index[11:0]   valid & ready
//   coef_stream  out        coefficient[16:0]    valid & ready
//   apb          in/out     frame_length, kind   psel & penable & pwrite
//
// one index per cycle while idx_stream.ready is high; a coefficient reaches coef_stream
// through 36 divider cells (the first loaded at the accepting edge), 2 fold/scale
// stages, 24 cordic cells, 4 mix stages and the output register.
// the whole chain moves while the skid register is empty;
// idx_stream.ready is low only while it holds a result. reset clears all
// valid bits and sets frame_length to 1024 and the kind to hann.
module window_coefficient_generator (
    input  logic                           clk,
    input  logic                           rst_n,
    wcg_index_if.sink                      idx_stream,
    wcg_coef_if.source                     coef_stream,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [wcg_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [wcg_pkg::APB_DATA_W-1:0] pwdata,
    output logic [wcg_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);
    import wcg_pkg::*;

    logic [FRAME_LEN_W-1:0] frame_length_reg;
    window_kind_t           kind_reg;
    logic [DIV_W-1:0]       divisor;
    logic                   advance;

    logic         div_valid [DIV_STAGES+1];
    div_data_t    div_data  [DIV_STAGES+1];
    logic         cos_valid [CORDIC_ITERS+1];
    cordic_pair_t cos_lanes [CORDIC_ITERS+1];

    logic              tail_valid;
    logic [COEF_W-1:0] tail_coef;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [COEF_W-1:0] out_data_reg;
    logic [COEF_W-1:0] out_data_next;
    logic              skid_valid_reg;
    logic              skid_valid_next;
    logic [COEF_W-1:0] skid_data_reg;
    logic [COEF_W-1:0] skid_data_next;

    // configuration port
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_length_reg <= FRAME_LEN_RESET;
            kind_reg         <= KIND_HANN;
        end
        else if (psel && penable && pwrite && pready)
        begin
            case (paddr[REG_SEL_BIT])
                REG_FRAME_LENGTH: frame_length_reg <= pwdata[FRAME_LEN_W-1:0];
                REG_WINDOW_KIND:  kind_reg <= window_kind_t'(pwdata[KIND_W-1:0]);
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[REG_SEL_BIT])
            REG_FRAME_LENGTH: prdata = APB_DATA_W'(frame_length_reg);
            REG_WINDOW_KIND:  prdata = APB_DATA_W'(kind_reg);
            default:          prdata = '0;
        endcase
    end

    // divisor is the clamped frame length minus one
    always_comb
    begin
        if (frame_length_reg < FRAME_LEN_W'(2))
        begin
            divisor = DIV_W'(1);
        end
        else if (32'(frame_length_reg) > MAX_FRAME)
        begin
            divisor = DIV_W'(MAX_FRAME - 1);
        end
        else
        begin
            divisor = DIV_W'(frame_length_reg - FRAME_LEN_W'(1));
        end
    end

    assign advance          = !skid_valid_reg;
    assign idx_stream.ready = advance;

    assign div_valid[0]     = idx_stream.valid && idx_stream.ready;
    assign div_data[0].num  = idx_stream.sample_index;
    assign div_data[0].rem  = '0;
    assign div_data[0].quot = '0;

    for (genvar i = 0; i < DIV_STAGES; i++)
    begin : g_div
        wcg_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (advance),
            .divisor   (divisor),
            .in_valid  (div_valid[i]),
            .in_data   (div_data[i]),
            .out_valid (div_valid[i+1]),
            .out_data  (div_data[i+1])
        );
    end

    wcg_cos_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (advance),
        .in_valid  (div_valid[DIV_STAGES]),
        .phase     (div_data[DIV_STAGES].quot),
        .out_valid (cos_valid[0]),
        .out_lanes (cos_lanes[0])
    );

    for (genvar i = 0; i < CORDIC_ITERS; i++)
    begin : g_cordic
        wcg_cordic_cell #(
            .ITER (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (advance),
            .in_valid  (cos_valid[i]),
            .in_lanes  (cos_lanes[i]),
            .out_valid (cos_valid[i+1]),
            .out_lanes (cos_lanes[i+1])
        );
    end

    wcg_mix u_mix (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (advance),
        .kind        (kind_reg),
        .in_valid    (cos_valid[CORDIC_ITERS]),
        .in_lanes    (cos_lanes[CORDIC_ITERS]),
        .out_valid   (tail_valid),
        .coefficient (tail_coef)
    );

    // output register with skid stage
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || coef_stream.ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = tail_valid;
                out_data_next  = tail_coef;
            end
        end
        else if (tail_valid && advance)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = tail_coef;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign coef_stream.valid       = out_valid_reg;
    assign coef_stream.coefficient = out_data_reg;

endmodule
